// ----- design/huffman_table_decoder_top_assert.svh -----
// ---------------------------------------------------------------------------
// huffman_table_decoder_top_assert.svh
// Assertion macros used by the decoder checker.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define HTD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("htd assertion failed");

// next-cycle implication
`define HTD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("htd assertion failed");

`endif

// ----- design/htd_pkg.sv -----
// ---------------------------------------------------------------------------
// htd_pkg
// Types, constants and helpers of the Huffman table decoder.
// ---------------------------------------------------------------------------
package htd_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CODE_LEN_DEF  = 32;
  localparam int BYTE_BITS         = 8;
  localparam int MAX_OUT           = 8;
  localparam int SYM_W             = 8;
  localparam int LEN_W             = 6;
  localparam int CODE_W            = 32;
  localparam int ENT_W             = SYM_W + LEN_W + CODE_W;
  localparam int CNT_W             = 9;

  localparam logic REG_ENTRY_COUNT   = 1'b0;
  localparam logic REG_TOTAL_SYMBOLS = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LSCAN,
    ST_LDEC,
    ST_CHECK,
    ST_MSCAN,
    ST_MDEC,
    ST_EMIT_ERR,
    ST_EMIT_SYM
  } state_t;

  typedef struct packed {
    logic take_item;
    logic rd_en;
    logic scan_long;
    logic long_clr;
    logic match_clr;
    logic append;
    logic clear_buf;
    logic emit_err;
    logic emit_sym;
  } cmd_t;

  typedef struct packed {
    logic             done;
    logic             long_zero;
    logic             overflow;
    logic             can_decode;
    logic             found;
    logic             out_busy;
    logic [CNT_W-1:0] slots;
  } status_t;

  function automatic logic [63:0] low_mask64(input logic [6:0] n);
    return ~(64'hFFFF_FFFF_FFFF_FFFF << n);
  endfunction

endpackage

// ----- design/htd_ram.sv -----
// ---------------------------------------------------------------------------
// htd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/htd_ctrl.sv -----
// ---------------------------------------------------------------------------
// htd_ctrl
// Sequencer: table scans, buffer append, symbol and error beats.
// ---------------------------------------------------------------------------
module htd_ctrl #(
  parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  htd_pkg::status_t                 status,
  output htd_pkg::cmd_t                    cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr
);
  import htd_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       n_r, n_nxt;
  logic             accept;
  logic             scan_more;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign scan_more = cnt_r < status.slots;
  assign rd_addr   = cnt_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_func == FUNC_DATA && !status.done) state_nxt = ST_LSCAN;
      end
      ST_LSCAN: begin
        if (!scan_more) state_nxt = ST_LDEC;
      end
      ST_LDEC: begin
        state_nxt = (status.long_zero || status.overflow) ? ST_EMIT_ERR : ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (n_r < 4'(MAX_OUT) && status.can_decode) ? ST_MSCAN : ST_IDLE;
      end
      ST_MSCAN: begin
        if (!scan_more) state_nxt = ST_MDEC;
      end
      ST_MDEC: begin
        state_nxt = status.found ? ST_EMIT_SYM : ST_EMIT_ERR;
      end
      ST_EMIT_ERR: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      ST_EMIT_SYM: begin
        if (!status.out_busy) state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    case (state_r)
      ST_IDLE: begin
        cmd.take_item = accept;
        cmd.long_clr  = accept;
        cnt_nxt       = '0;
      end
      ST_LSCAN: begin
        cmd.rd_en     = scan_more;
        cmd.scan_long = 1'b1;
        if (scan_more) cnt_nxt = cnt_r + 1'b1;
      end
      ST_LDEC: begin
        cmd.clear_buf = status.long_zero || status.overflow;
        cmd.append    = !(status.long_zero || status.overflow);
        n_nxt         = '0;
      end
      ST_CHECK: begin
        cmd.match_clr = 1'b1;
        cnt_nxt       = '0;
      end
      ST_MSCAN: begin
        cmd.rd_en = scan_more;
        if (scan_more) cnt_nxt = cnt_r + 1'b1;
      end
      ST_MDEC: begin
        cmd.clear_buf = !status.found;
      end
      ST_EMIT_ERR: begin
        cmd.emit_err = !status.out_busy;
      end
      ST_EMIT_SYM: begin
        cmd.emit_sym = !status.out_busy;
        if (!status.out_busy) n_nxt = n_r + 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

// ----- design/htd_dp.sv -----
// ---------------------------------------------------------------------------
// htd_dp
// Datapath: code table, bit buffer, match unit, registers, result register.
// ---------------------------------------------------------------------------
module htd_dp #(
  parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN  = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  htd_pkg::cmd_t                    cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
  output htd_pkg::status_t                 status,
  input  logic                             in_func,
  input  logic [7:0]                       in_entry_index,
  input  logic [7:0]                       in_entry_symbol,
  input  logic [5:0]                       in_entry_length,
  input  logic [31:0]                      in_entry_code,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_symbol,
  output logic                             out_last,
  output logic                             out_error,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata
);
  import htd_pkg::*;

  localparam int AW     = $clog2(TABLE_ENTRIES);
  localparam int BUF_W  = MAX_CODE_LEN + BYTE_BITS;
  localparam int FILL_W = $clog2(BUF_W + 1);

  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]       emitted_r, emitted_nxt;
  logic [LEN_W-1:0]  longest_r, longest_nxt;
  logic              found_r, found_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [SYM_W-1:0]  best_sym_r, best_sym_nxt;
  logic [7:0]        byte_r;
  logic              pend_r, pend_long_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_symbol_r, out_symbol_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_error_r, out_error_nxt;

  logic              we;
  logic [ENT_W-1:0]  rdata;
  logic [SYM_W-1:0]  ent_sym;
  logic [LEN_W-1:0]  ent_len;
  logic [CODE_W-1:0] ent_code;
  logic              len_ok;
  logic [6:0]        fill7;
  logic [6:0]        sh;
  logic [63:0]       head;
  logic              hit;
  logic [FILL_W-1:0] fill_less;
  logic              cfg_we;

  assign we = cmd.take_item && in_func == FUNC_LOAD &&
              {1'b0, in_entry_index} < CNT_W'(TABLE_ENTRIES);

  htd_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (in_entry_index[AW-1:0]),
    .wdata ({in_entry_symbol, in_entry_length, in_entry_code}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign ent_sym  = rdata[ENT_W-1 -: SYM_W];
  assign ent_len  = rdata[CODE_W +: LEN_W];
  assign ent_code = rdata[CODE_W-1:0];
  assign len_ok   = ent_len != '0 && ent_len <= LEN_W'(MAX_CODE_LEN);
  assign fill7    = 7'(fill_r);
  assign sh       = fill7 - {1'b0, ent_len};
  assign head     = (64'(buf_r) >> sh[5:0]) & low_mask64({1'b0, ent_len});
  assign hit      = len_ok && {1'b0, ent_len} <= fill7 &&
                    head == (64'(ent_code) & low_mask64({1'b0, ent_len})) &&
                    (!found_r || ent_len < best_len_r);
  assign fill_less = fill_r - FILL_W'(best_len_r);

  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TOTAL_SYMBOLS) ? total_r : 32'(entry_count_r);

  assign status.done       = emitted_r >= total_r;
  assign status.long_zero  = longest_r == '0;
  assign status.overflow   = fill7 > 7'(MAX_CODE_LEN);
  assign status.can_decode = fill7 >= {1'b0, longest_r} && !(emitted_r >= total_r);
  assign status.found      = found_r;
  assign status.out_busy   = out_valid_r && !out_ready;
  assign status.slots      = (entry_count_r > CNT_W'(TABLE_ENTRIES)) ?
                             CNT_W'(TABLE_ENTRIES) : entry_count_r;

  always_comb begin
    entry_count_nxt = entry_count_r;
    total_nxt       = total_r;
    if (cfg_we && paddr[2] == REG_ENTRY_COUNT)   entry_count_nxt = pwdata[CNT_W-1:0];
    if (cfg_we && paddr[2] == REG_TOTAL_SYMBOLS) total_nxt = pwdata;
  end

  always_comb begin
    longest_nxt  = longest_r;
    found_nxt    = found_r;
    best_len_nxt = best_len_r;
    best_sym_nxt = best_sym_r;
    if (cmd.long_clr)  longest_nxt = '0;
    if (cmd.match_clr) found_nxt = 1'b0;
    if (pend_r && pend_long_r) begin
      if (len_ok && ent_len > longest_r) longest_nxt = ent_len;
    end else if (pend_r && hit) begin
      found_nxt    = 1'b1;
      best_len_nxt = ent_len;
      best_sym_nxt = ent_sym;
    end
  end

  always_comb begin
    buf_nxt     = buf_r;
    fill_nxt    = fill_r;
    emitted_nxt = emitted_r;
    if (cmd.clear_buf) begin
      buf_nxt  = '0;
      fill_nxt = '0;
    end else if (cmd.append) begin
      buf_nxt  = {buf_r[BUF_W-BYTE_BITS-1:0], byte_r};
      fill_nxt = fill_r + FILL_W'(BYTE_BITS);
    end else if (cmd.emit_sym) begin
      fill_nxt    = fill_less;
      buf_nxt     = buf_r & BUF_W'(low_mask64(7'(fill_less)));
      emitted_nxt = emitted_r + 32'd1;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_error_nxt  = out_error_r;
    if (cmd.emit_err) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = '0;
      out_last_nxt   = 1'b0;
      out_error_nxt  = 1'b1;
    end else if (cmd.emit_sym) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = best_sym_r;
      out_last_nxt   = (emitted_r + 32'd1) == total_r;
      out_error_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CNT_W'(1);
      total_r       <= '0;
      buf_r         <= '0;
      fill_r        <= '0;
      emitted_r     <= '0;
      longest_r     <= '0;
      found_r       <= 1'b0;
      pend_r        <= 1'b0;
      pend_long_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      total_r       <= total_nxt;
      buf_r         <= buf_nxt;
      fill_r        <= fill_nxt;
      emitted_r     <= emitted_nxt;
      longest_r     <= longest_nxt;
      found_r       <= found_nxt;
      pend_r        <= cmd.rd_en;
      pend_long_r   <= cmd.scan_long;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_len_r   <= best_len_nxt;
    best_sym_r   <= best_sym_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_error_r  <= out_error_nxt;
    if (cmd.take_item) byte_r <= in_data_byte;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_error  = out_error_r;

endmodule

// ----- design/huffman_table_decoder_top.sv -----
// Load beat: table slot written at acceptance; loads can follow back to back.
// Data beat, S = min(entry_count, TABLE_ENTRIES): accept, longest-code scan over S slots,
// then per symbol a match scan over the S slots (one table read per slot per cycle), up to 8
// symbols, and one closing check. A stalled result holds the sequencer until it is taken.
// Reset: synchronous active-low rst_n; no clearing pass, table undefined until loaded.
// ---------------------------------------------------------------------------
// huffman_table_decoder_top
// Huffman decoder with a loaded code table and an APB register port.
// ---------------------------------------------------------------------------
module huffman_table_decoder_top #(
  parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN  = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_entry_symbol,
  input  logic [5:0]  in_entry_length,
  input  logic [31:0] in_entry_code,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_symbol,
  output logic        out_last,
  output logic        out_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import htd_pkg::*;

  cmd_t                             cmd;
  status_t                          status;
  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr;

  assign pready = 1'b1;

  htd_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .status   (status),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  htd_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_LEN(MAX_CODE_LEN)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .status          (status),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_symbol (in_entry_symbol),
    .in_entry_length (in_entry_length),
    .in_entry_code   (in_entry_code),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_last        (out_last),
    .out_error       (out_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

// ----- design/htd_checker.sv -----
// ---------------------------------------------------------------------------
// htd_checker
// Port-level checks of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "huffman_table_decoder_top_assert.svh"

module htd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_symbol,
  input logic        out_last,
  input logic        out_error,
  input logic [2:0]  paddr,
  input logic [31:0] prdata
);

  `HTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(out_last) && $stable(out_error))
  `HTD_ASSERT_NOW(a_err_clean, clk, rst_n, out_valid && out_error, out_symbol == 8'd0 && !out_last)
  `HTD_ASSERT_NOW(a_cnt_width, clk, rst_n, !paddr[2], prdata[31:9] == 23'd0)

endmodule

bind huffman_table_decoder_top htd_checker u_htd_checker (.*);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - Huffman table decoder testbench
// Loads code tables, streams encoded bytes and checks every decoded beat.
// A shadow decoder predicts the symbol, last and error fields of each result.
// The register writes happen only while the decoder is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import htd_pkg::*;

  localparam int SETTLE_CYCLES = 3000;
  localparam int FILL_SLOTS = 16;
  localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;
  localparam logic [2:0] ADDR_TOTAL_SYMBOLS = 3'd4;
  localparam int MODE_FIXED = 0;
  localparam int MODE_UNARY = 1;
  localparam int MODE_RANDOM = 2;

  typedef struct {
    logic        func;
    logic [7:0]  idx;
    logic [7:0]  sym;
    logic [5:0]  len;
    logic [31:0] code;
    logic [7:0]  data;
  } beat_t;

  typedef struct {
    logic [7:0] sym;
    logic       last;
    logic       err;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [7:0]  in_entry_index = '0;
  logic [7:0]  in_entry_symbol = '0;
  logic [5:0]  in_entry_length = '0;
  logic [31:0] in_entry_code = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_symbol;
  logic        out_last;
  logic        out_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  huffman_table_decoder_top dut (.*);

  beat_t    pending_beats[$];
  decoded_t expected_syms[$];
  int       mismatch_count = 0;
  int       hold_requests = 0;

  // shadow decoder state
  logic [7:0]  sh_sym[256];
  logic [5:0]  sh_len[256];
  logic [31:0] sh_code[256];
  logic [63:0] sh_buf = '0;
  int          sh_fill = 0;
  logic [31:0] sh_emitted = '0;
  logic [8:0]  sh_entry_count = 9'd1;
  logic [31:0] sh_total = '0;

  // tables as queued by the stimulus
  logic [5:0]  gen_len[256];
  logic [31:0] gen_code[256];
  int          gen_slots = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12.0 * 1500000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [63:0] mask_of(input int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic bit len_valid(input logic [5:0] l);
    return l >= 6'd1 && l <= 6'd32;
  endfunction

  task automatic push_decoded(input logic [7:0] s, input logic l, input logic e);
    decoded_t d;
    d.sym = s;
    d.last = l;
    d.err = e;
    expected_syms.push_back(d);
  endtask

  task automatic decode_beat(input beat_t b);
    int slots, longest, n, best, best_len, len;
    bit found;
    if (b.func == FUNC_LOAD) begin
      sh_sym[b.idx] = b.sym;
      sh_len[b.idx] = b.len;
      sh_code[b.idx] = b.code;
      return;
    end
    if (sh_emitted >= sh_total) return;
    slots = (sh_entry_count > 9'd256) ? 256 : int'(sh_entry_count);
    longest = 0;
    for (int i = 0; i < slots; i++)
      if (len_valid(sh_len[i]) && int'(sh_len[i]) > longest) longest = int'(sh_len[i]);
    if (longest == 0 || sh_fill > 32) begin
      sh_buf = '0;
      sh_fill = 0;
      push_decoded(8'd0, 1'b0, 1'b1);
      return;
    end
    sh_buf = (sh_buf << 8) | 64'(b.data);
    sh_fill += 8;
    n = 0;
    while (n < MAX_OUT && sh_fill >= longest && sh_emitted < sh_total) begin
      found = 0;
      best = 0;
      best_len = 0;
      for (int i = 0; i < slots; i++) begin
        if (!len_valid(sh_len[i])) continue;
        len = int'(sh_len[i]);
        if (((sh_buf >> (sh_fill - len)) & mask_of(len)) ==
            (64'(sh_code[i]) & mask_of(len)) && (!found || len < best_len)) begin
          found = 1;
          best = i;
          best_len = len;
        end
      end
      if (!found) begin
        sh_buf = '0;
        sh_fill = 0;
        push_decoded(8'd0, 1'b0, 1'b1);
        break;
      end
      sh_fill -= best_len;
      sh_buf &= mask_of(sh_fill);
      sh_emitted++;
      push_decoded(sh_sym[best], sh_emitted == sh_total, 1'b0);
      n++;
    end
  endtask

  // driver
  bit in_taken = 0;
  int in_gap = 0;
  bit in_no_gaps = 0;

  always @(posedge clk) begin
    beat_t b;
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      b.func = in_func;
      b.idx = in_entry_index;
      b.sym = in_entry_symbol;
      b.len = in_entry_length;
      b.code = in_entry_code;
      b.data = in_data_byte;
      decode_beat(b);
    end
  end

  always @(negedge clk) begin
    beat_t b;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        in_func <= b.func;
        in_entry_index <= b.idx;
        in_entry_symbol <= b.sym;
        in_entry_length <= b.len;
        in_entry_code <= b.code;
        in_data_byte <= b.data;
        in_valid <= 1'b1;
        if (!in_no_gaps)
          in_gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  int out_hold = 0;
  int hold_seen = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      out_hold = 600;
    end
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if (in_no_gaps) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_hold = ($urandom_range(0, 10) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    decoded_t d;
    if (rst_n && out_valid && out_ready) begin
      if (expected_syms.size() == 0) begin
        report("unexpected beat symbol", int'(out_symbol), 0);
      end else begin
        d = expected_syms.pop_front();
        if (out_symbol !== d.sym) report("symbol", int'(out_symbol), int'(d.sym));
        if (out_last !== d.last) report("last", int'(out_last), int'(d.last));
        if (out_error !== d.err) report("error", int'(out_error), int'(d.err));
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_ENTRY_COUNT) sh_entry_count = value[8:0];
    else sh_total = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_beats.size() == 0 && !in_valid && expected_syms.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_load(input int idx, input logic [7:0] s, input logic [5:0] l,
                            input logic [31:0] c);
    beat_t b;
    b.func = FUNC_LOAD;
    b.idx = 8'(idx);
    b.sym = s;
    b.len = l;
    b.code = c;
    b.data = 8'($urandom());
    pending_beats.push_back(b);
    gen_len[idx] = l;
    gen_code[idx] = c;
  endtask

  task automatic load_table(input int mode, input int k);
    logic [5:0] l;
    logic [31:0] c;
    logic [63:0] junk;
    for (int i = 0; i < k; i++) begin
      junk = {$urandom(), $urandom()};
      case (mode)
        MODE_FIXED: begin
          l = 6'($clog2(k));
          c = 32'(i);
        end
        MODE_UNARY: begin
          l = 6'((i == k - 1) ? k - 1 : i + 1);
          c = (i == k - 1) ? 32'(mask_of(k - 1)) : 32'(mask_of(i) << 1);
        end
        default: begin
          l = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(1, 6));
          c = $urandom();
        end
      endcase
      c = c | 32'(junk << l);
      queue_load(i, 8'($urandom()), l, c);
    end
    gen_slots = k;
  endtask

  task automatic queue_bytes(input int nbytes, input int noise_pct);
    bit bits[$];
    beat_t b;
    int s;
    while (bits.size() < nbytes * 8) begin
      s = $urandom_range(0, gen_slots - 1);
      if (!len_valid(gen_len[s])) begin
        bits.push_back(1'($urandom()));
        continue;
      end
      for (int j = int'(gen_len[s]) - 1; j >= 0; j--) bits.push_back(gen_code[s][j]);
    end
    for (int i = 0; i < nbytes; i++) begin
      b.func = FUNC_DATA;
      b.idx = 8'($urandom());
      b.sym = 8'($urandom());
      b.len = 6'($urandom());
      b.code = $urandom();
      for (int j = 7; j >= 0; j--) b.data[j] = bits[i * 8 + 7 - j];
      if ($urandom_range(0, 99) < noise_pct) b.data = 8'($urandom());
      pending_beats.push_back(b);
    end
  endtask

  task automatic run_phase(input int ec, input logic [31:0] total, input int mode, input int k,
                           input int nbytes, input int noise_pct);
    wait_idle();
    reg_write(ADDR_ENTRY_COUNT, 32'(ec));
    reg_write(ADDR_TOTAL_SYMBOLS, total);
    if (k > 0) load_table(mode, k);
    queue_bytes(nbytes, noise_pct);
  endtask

  initial begin
    int ec, k, mode;
    logic [31:0] total;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the low slots start with a length that never matches
    for (int i = 0; i < FILL_SLOTS; i++)
      queue_load(i, 8'($urandom()),
                 ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63)), $urandom());
    gen_slots = 1;

    run_phase(0, 5, MODE_FIXED, 0, 2, 100);
    run_phase(FILL_SLOTS, 5, MODE_FIXED, 0, 1, 100);
    run_phase(4, 20, MODE_FIXED, 4, 7, 0);
    wait_idle();
    reg_write(ADDR_TOTAL_SYMBOLS, 32'hFFFF_FFFF);
    queue_bytes(2, 0);
    run_phase(2, 32'hFFFF_FFFF, MODE_FIXED, 2, 3, 0);
    run_phase(6, 40, MODE_UNARY, 6, 6, 0);
    run_phase(5, 30, MODE_RANDOM, 5, 5, 30);
    run_phase(0, 0, MODE_FIXED, 0, 2, 100);

    // back pressure: receiver holds off while the sender keeps offering beats
    wait_idle();
    reg_write(ADDR_ENTRY_COUNT, 32'd2);
    reg_write(ADDR_TOTAL_SYMBOLS, 32'hFFFF_FFFF);
    load_table(MODE_FIXED, 2);
    hold_requests++;
    in_no_gaps = 1;
    queue_bytes(10, 0);
    wait_idle();
    in_no_gaps = 0;

    for (int p = 0; p < 5; p++) begin
      mode = $urandom_range(0, 2);
      case (mode)
        MODE_FIXED: k = 1 << $urandom_range(1, 3);
        MODE_UNARY: k = $urandom_range(2, 8);
        default: k = $urandom_range(2, 12);
      endcase
      ec = k;
      if ($urandom_range(0, 6) == 0) ec = $urandom_range(k, FILL_SLOTS);
      case ($urandom_range(0, 5))
        0: total = 32'hFFFF_FFFF;
        1: total = 0;
        default: total = $urandom_range(5, 60);
      endcase
      run_phase(ec, total, mode, k, $urandom_range(5, 12),
                ($urandom_range(0, 3) == 0) ? 40 : 0);
    end

    wait_idle();
    if (expected_syms.size() != 0) report("results left over", expected_syms.size(), 0);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- huffman_table_decoder_top.f -----
+incdir+design
design/htd_pkg.sv
design/htd_ram.sv
design/htd_ctrl.sv
design/htd_dp.sv
design/huffman_table_decoder_top.sv
design/htd_checker.sv
dv/tb_top.sv
